>>> rtl/ddos_pkg.sv
// Package: shared constants, payload types and the arctangent table for the odometry step.
package ddos_pkg;

    localparam int CordicSteps = 20;
    localparam int StepW = $clog2(CordicSteps + 1);

    localparam int HtW = 10;
    localparam logic [HtW-1:0] HtReset = 10'd118;
    localparam logic [HtW-1:0] HtMin = 10'd16;

    localparam int DeltaW = 24;
    localparam int SpeedW = 16;
    localparam int OutW = 28;

    localparam int MagW = 36;
    localparam int YawW = 38;
    localparam int DispW = 27;
    localparam int GainW = 30;
    localparam int VecW = 40;
    localparam int DegW = 23;
    localparam int DegProdW = 60;

    localparam logic signed [YawW-1:0] PiQ28 = 38'sd843314857;
    localparam logic signed [YawW-1:0] HalfPiQ28 = 38'sd421657428;
    localparam logic signed [YawW-1:0] TwoPiQ28 = 38'sd1686629713;
    localparam logic [GainW-1:0] GainQ30 = 30'd652032874;
    localparam logic [DegW-1:0] DegPerRadQ16 = 23'd3754936;
    localparam logic signed [VecW-1:0] OutMax = 40'sd134217727;
    localparam logic signed [VecW-1:0] OutMin = -40'sd134217728;

    localparam logic ActionMotor = 1'b0;
    localparam logic ActionOdom = 1'b1;

    typedef struct packed {
        logic                     action;
        logic                     cmd_accepted;
        logic signed [SpeedW-1:0] left_speed_mm_s;
        logic signed [SpeedW-1:0] right_speed_mm_s;
        logic [DeltaW-1:0]        left_delta_q16;
        logic [DeltaW-1:0]        right_delta_q16;
        logic                     on_ground;
    } req_t;

    typedef struct packed {
        logic signed [OutW-1:0] dx_q16;
        logic signed [OutW-1:0] dy_q16;
        logic signed [OutW-1:0] dtheta_deg_q16;
        logic                   traction_lost;
    } rsp_t;

    function automatic logic [29:0] atan_q28(input logic [4:0] i);
        logic [29:0] v;
        begin
            unique case (i)
                5'd0:  v = 30'd210828714;
                5'd1:  v = 30'd124459457;
                5'd2:  v = 30'd65760959;
                5'd3:  v = 30'd33381290;
                5'd4:  v = 30'd16755422;
                5'd5:  v = 30'd8385879;
                5'd6:  v = 30'd4193963;
                5'd7:  v = 30'd2097109;
                5'd8:  v = 30'd1048571;
                5'd9:  v = 30'd524287;
                5'd10: v = 30'd262144;
                5'd11: v = 30'd131072;
                5'd12: v = 30'd65536;
                5'd13: v = 30'd32768;
                5'd14: v = 30'd16384;
                5'd15: v = 30'd8192;
                5'd16: v = 30'd4096;
                5'd17: v = 30'd2048;
                5'd18: v = 30'd1024;
                5'd19: v = 30'd512;
                5'd20: v = 30'd256;
                5'd21: v = 30'd128;
                5'd22: v = 30'd64;
                5'd23: v = 30'd32;
                5'd24: v = 30'd16;
                5'd25: v = 30'd8;
                5'd26: v = 30'd4;
                5'd27: v = 30'd2;
                5'd28: v = 30'd1;
                default: v = 30'd0;
            endcase
            return v;
        end
    endfunction

endpackage

>>> rtl/ddos_if.sv
// Interfaces: request and result channels with valid/ready handshake.
interface ddos_req_if import ddos_pkg::*; ();
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ddos_rsp_if import ddos_pkg::*; ();
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/ddos_serial_mul.sv
// Module: unsigned shift-and-add multiplier, one multiplier bit per cycle.
module ddos_serial_mul import ddos_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [MagW-1:0]     a,
    input  logic [GainW-1:0]    b,
    output logic                done,
    output logic [DegProdW+6:0] prod
);
    localparam int PW = DegProdW + 7;
    localparam int CW = $clog2(GainW + 1);

    logic [PW-1:0]   acc_reg, acc_next;
    logic [PW-1:0]   a_reg, a_next;
    logic [GainW-1:0] b_reg, b_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;

    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            a_next    = PW'(a);
            b_next    = b;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_next = acc_reg + a_reg;
            end
            a_next   = a_reg << 1;
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(GainW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule

>>> rtl/diff_drive_odometry_step_top.sv
// Top level: two-wheel dead-reckoning step with serial divider, a shared serial multiplier and CORDIC.
//
//  channel | dir | handshake     | payload
//  req     | in  | valid/ready   | req_t (command or odometry sample)
//  rsp     | out | valid/ready   | rsp_t (dx, dy, heading change, traction flag)
//  apb     | in  | psel/penable  | half_track_mm at byte 0
//
// A command item is handled in the cycle it is taken. An odometry item passes
// through the restoring divider (load, then one quotient bit a cycle), the serial
// degree and gain multiplies, the angle reduction, CordicSteps CORDIC iterations
// and the output step.
// The first sample after reset goes straight to the output step with zero dx, dy and heading change.
// Reset clears the direction latches and the result-valid flag and sets the first-sample flag.
// A waiting result holds in the output register; the next request is taken
// only once that register is free.
module diff_drive_odometry_step_top import ddos_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    ddos_req_if.sink    req,
    ddos_rsp_if.source  rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_DIV  = 8'b00000010,
        S_DEG  = 8'b00000100,
        S_GAIN = 8'b00001000,
        S_RED  = 8'b00010000,
        S_ROT  = 8'b00100000,
        S_OUT  = 8'b01000000,
        S_WAIT = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    logic [HtW-1:0] ht_reg, ht_next;
    logic first_reg, first_next;
    logic lrev_reg, lrev_next;
    logic rrev_reg, rrev_next;

    logic signed [DeltaW+1:0] diff_reg, diff_next;
    logic signed [DispW-1:0]  disp_reg, disp_next;
    logic [MagW-1:0] rem_reg, rem_next;
    logic [MagW-1:0] quo_reg, quo_next;
    logic [MagW-1:0] num_reg, num_next;
    logic [5:0]      dcnt_reg, dcnt_next;
    logic signed [YawW-1:0] yaw_reg, yaw_next;
    logic signed [VecW-1:0] x_reg, x_next;
    logic signed [VecW-1:0] y_reg, y_next;
    logic signed [OutW-1:0] deg_reg, deg_next;
    logic [StepW-1:0] step_reg, step_next;
    logic signed [SpeedW-1:0] lsp_reg, lsp_next;
    logic signed [SpeedW-1:0] rsp_sp_reg, rsp_sp_next;
    logic gnd_reg, gnd_next;
    logic zero_reg, zero_next;

    logic rv_reg, rv_next;
    rsp_t rd_reg, rd_next;

    logic mul_start;
    logic [MagW-1:0] mul_a;
    logic [GainW-1:0] mul_b;
    logic mul_done;
    logic [DegProdW+6:0] mul_prod;

    logic req_fire;
    logic cfg_wr;
    logic [MagW:0] trial;
    logic signed [VecW-1:0] xs, ys;
    logic signed [VecW-1:0] xo, yo;
    logic [VecW-1:0] xabs, yabs;
    logic [DegProdW+6:0] degm;
    logic [DeltaW+1:0] dabs;

    ddos_serial_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    assign pready  = 1'b1;
    assign prdata  = {{(32-HtW){1'b0}}, ht_reg};
    assign cfg_wr  = psel && penable && pwrite && (paddr == 2'd0);
    assign req.ready = (state_reg == S_IDLE) && !rv_reg;
    assign req_fire  = req.valid && req.ready;
    assign rsp.valid = rv_reg;
    assign rsp.data  = rd_reg;

    function automatic logic signed [OutW-1:0] sat(input logic signed [VecW-1:0] v);
        logic signed [OutW-1:0] r;
        begin
            if (v > OutMax)
            begin
                r = OutMax[OutW-1:0];
            end
            else if (v < OutMin)
            begin
                r = OutMin[OutW-1:0];
            end
            else
            begin
                r = v[OutW-1:0];
            end
            return r;
        end
    endfunction

    always_comb
    begin
        logic signed [DeltaW+1:0] l, r;
        state_next = state_reg;
        ht_next    = cfg_wr ? pwdata[HtW-1:0] : ht_reg;
        first_next = first_reg;
        lrev_next  = lrev_reg;
        rrev_next  = rrev_reg;
        diff_next  = diff_reg;
        disp_next  = disp_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        num_next   = num_reg;
        dcnt_next  = dcnt_reg;
        yaw_next   = yaw_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        deg_next   = deg_reg;
        step_next  = step_reg;
        lsp_next   = lsp_reg;
        rsp_sp_next = rsp_sp_reg;
        gnd_next   = gnd_reg;
        zero_next  = zero_reg;
        rv_next    = rv_reg;
        rd_next    = rd_reg;
        mul_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        trial      = '0;
        xs = x_reg >>> step_reg;
        ys = y_reg >>> step_reg;
        xo = '0;
        yo = '0;
        xabs = '0;
        yabs = '0;
        degm = '0;
        l = '0;
        r = '0;
        dabs = diff_reg[DeltaW+1] ? (DeltaW+2)'(0) - diff_reg : diff_reg;

        if (rv_reg && rsp.ready)
        begin
            rv_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    lsp_next    = req.data.left_speed_mm_s;
                    rsp_sp_next = req.data.right_speed_mm_s;
                    gnd_next    = req.data.on_ground;
                    if (req.data.action == ActionMotor)
                    begin
                        if (req.data.cmd_accepted)
                        begin
                            if (req.data.left_speed_mm_s != 0)
                                lrev_next = req.data.left_speed_mm_s[SpeedW-1];
                            if (req.data.right_speed_mm_s != 0)
                                rrev_next = req.data.right_speed_mm_s[SpeedW-1];
                        end
                    end
                    else if (first_reg)
                    begin
                        first_next = 1'b0;
                        zero_next  = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        zero_next = 1'b0;
                        l = lrev_reg ? -$signed({2'b0, req.data.left_delta_q16})
                                     : $signed({2'b0, req.data.left_delta_q16});
                        r = rrev_reg ? -$signed({2'b0, req.data.right_delta_q16})
                                     : $signed({2'b0, req.data.right_delta_q16});
                        diff_next = r - l;
                        disp_next = DispW'(l) + DispW'(r);
                        rem_next  = '0;
                        quo_next  = '0;
                        dcnt_next = '0;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (dcnt_reg == 6'd0)
                begin
                    num_next  = MagW'({dabs, 11'b0});
                    dcnt_next = 6'd1;
                end
                else
                begin
                    trial = {rem_reg, num_reg[MagW-1]};
                    num_next = num_reg << 1;
                    if (trial >= (MagW+1)'(ht_reg < HtMin ? HtMin : ht_reg))
                    begin
                        rem_next = MagW'(trial - (MagW+1)'(ht_reg < HtMin ? HtMin : ht_reg));
                        quo_next = {quo_reg[MagW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = trial[MagW-1:0];
                        quo_next = {quo_reg[MagW-2:0], 1'b0};
                    end
                    if (dcnt_reg == 6'(MagW))
                    begin
                        state_next = S_DEG;
                        mul_start  = 1'b1;
                        mul_a      = quo_next;
                        mul_b      = GainW'(DegPerRadQ16);
                    end
                    else
                    begin
                        dcnt_next = dcnt_reg + 1'b1;
                    end
                end
            end
            S_DEG:
            begin
                if (mul_done)
                begin
                    degm = mul_prod >> 28;
                    deg_next = sat(diff_reg[DeltaW+1] ? -$signed(VecW'(degm))
                                                       : $signed(VecW'(degm)));
                    yaw_next = diff_reg[DeltaW+1] ? -$signed({2'b0, quo_reg})
                                                  : $signed({2'b0, quo_reg});
                    mul_start = 1'b1;
                    mul_a = MagW'(disp_reg[DispW-1] ? -disp_reg : disp_reg);
                    mul_b = GainQ30;
                    state_next = S_GAIN;
                end
            end
            S_GAIN:
            begin
                if (mul_done)
                begin
                    xabs = VecW'(mul_prod >> 24);
                    x_next = disp_reg[DispW-1] ? -$signed(xabs) : $signed(xabs);
                    y_next = '0;
                    state_next = S_RED;
                    dcnt_next = '0;
                end
            end
            S_RED:
            begin
                // one reduction step a cycle, then the half-turn fold
                if (yaw_reg > PiQ28 && dcnt_reg < 6'd4)
                begin
                    yaw_next = yaw_reg - TwoPiQ28;
                    dcnt_next = dcnt_reg + 1'b1;
                end
                else if (yaw_reg < -PiQ28 && dcnt_reg < 6'd4)
                begin
                    yaw_next = yaw_reg + TwoPiQ28;
                    dcnt_next = dcnt_reg + 1'b1;
                end
                else
                begin
                    if (yaw_reg > HalfPiQ28)
                    begin
                        yaw_next = yaw_reg - PiQ28;
                        x_next = -x_reg;
                    end
                    else if (yaw_reg < -HalfPiQ28)
                    begin
                        yaw_next = yaw_reg + PiQ28;
                        x_next = -x_reg;
                    end
                    step_next = '0;
                    state_next = S_ROT;
                end
            end
            S_ROT:
            begin
                if (yaw_reg >= 0)
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    yaw_next = yaw_reg - $signed(YawW'(atan_q28(5'(step_reg))));
                end
                else
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    yaw_next = yaw_reg + $signed(YawW'(atan_q28(5'(step_reg))));
                end
                if (step_reg == StepW'(CordicSteps - 1))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_OUT:
            begin
                xabs = x_reg[VecW-1] ? VecW'(0) - x_reg : x_reg;
                yabs = y_reg[VecW-1] ? VecW'(0) - y_reg : y_reg;
                xo = x_reg[VecW-1] ? -$signed(xabs >> 7) : $signed(xabs >> 7);
                yo = y_reg[VecW-1] ? -$signed(yabs >> 7) : $signed(yabs >> 7);
                rd_next.dx_q16 = zero_reg ? '0 : sat(xo);
                rd_next.dy_q16 = zero_reg ? '0 : sat(yo);
                rd_next.dtheta_deg_q16 = zero_reg ? '0 : deg_reg;
                rd_next.traction_lost = !gnd_reg;
                rv_next = 1'b1;
                if (lsp_reg != 0)
                    lrev_next = lsp_reg[SpeedW-1];
                if (rsp_sp_reg != 0)
                    rrev_next = rsp_sp_reg[SpeedW-1];
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ht_reg    <= HtReset;
            first_reg <= 1'b1;
            lrev_reg  <= 1'b0;
            rrev_reg  <= 1'b0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ht_reg    <= ht_next;
            first_reg <= first_next;
            lrev_reg  <= lrev_next;
            rrev_reg  <= rrev_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg   <= diff_next;
        disp_reg   <= disp_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        num_reg    <= num_next;
        dcnt_reg   <= dcnt_next;
        yaw_reg    <= yaw_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        deg_reg    <= deg_next;
        step_reg   <= step_next;
        lsp_reg    <= lsp_next;
        rsp_sp_reg <= rsp_sp_next;
        gnd_reg    <= gnd_next;
        zero_reg   <= zero_next;
        rd_reg     <= rd_next;
    end
endmodule

>>> rtl/ddos_checker.sv
// Checker: port-level properties of the odometry step, bound to the top level.
module ddos_port_checker import ddos_pkg::*; (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp_data,
    input logic pready
);
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result dropped or changed while stalled");

    a_no_take_while_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("request taken while a result waits");

    a_no_rsp_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !rsp_valid)
        else $error("result appeared in the cycle after a request");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");
endmodule

bind diff_drive_odometry_step_top ddos_port_checker u_ddos_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data),
    .pready    (pready)
);
